### rtl/tkss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the top-k score selector.
// Used by the channel interfaces, the candidate cell and the top level.
package tkss_pkg;

  localparam int KMaxDefault = 64;
  localparam int ScoreW      = 32;
  localparam int LabelW      = 32;
  localparam int KW          = 7;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 32;

  localparam logic [CfgIdxW-1:0] CfgQueryKind = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgK         = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRadius    = 2'd2;

  localparam logic QueryTopK  = 1'b0;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusTout = 1'b1;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic [LabelW-1:0]        label_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_op_e op;
    score_t   score;
    label_t   label;
  } cell_ctrl_t;

endpackage

### rtl/tkss_in_if.sv
`timescale 1ns / 1ps
// Input channel of the top-k score selector: valid/ready plus one scored vector.
// Depends on tkss_pkg for the payload types.
interface tkss_in_if;
  logic              valid;
  logic              ready;
  tkss_pkg::score_t  score;
  tkss_pkg::label_t  label;
  logic              has_score;
  logic              last_item;
  logic              abort;

  modport source (output valid, score, label, has_score, last_item, abort, input ready);
  modport sink   (input valid, score, label, has_score, last_item, abort, output ready);
endinterface

### rtl/tkss_out_if.sv
`timescale 1ns / 1ps
// Result channel of the top-k score selector: valid/ready plus one result.
// Depends on tkss_pkg for the payload types.
interface tkss_out_if;
  logic              valid;
  logic              ready;
  tkss_pkg::label_t  result_label;
  tkss_pkg::score_t  result_score;
  logic              has_entry;
  logic              status;
  logic              query_end;

  modport source (output valid, result_label, result_score, has_entry, status, query_end,
                  input ready);
  modport sink   (input valid, result_label, result_score, has_entry, status, query_end,
                  output ready);
endinterface

### rtl/top_k_score_selector.sv
`timescale 1ns / 1ps
// Streaming top-k / range score selector. Scores arrive one beat per cycle
// while in_i.ready is high; in top-k mode each beat is placed into a sorted
// chain of K_MAX cells in the cycle it is taken. The ending beat of a top-k
// query drains the chain from its head, one result beat per cycle while the
// output is free, and no input beat is taken while it drains. Range mode and
// abort yield at most one result per input beat, held in the output register
// until taken. Ties keep the earlier arrival first; k above K_MAX acts as K_MAX.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i (0 query kind,
// 1 k, 2 radius); the user must write it only while idle, which the block does not enforce.
// Depends on tkss_pkg, tkss_in_if, tkss_out_if and tkss_cell.
module top_k_score_selector #(
  parameter int K_MAX = tkss_pkg::KMaxDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tkss_in_if.sink                         in_i,
  tkss_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [tkss_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tkss_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int CW = $clog2(K_MAX + 1);
  localparam int XW = (CW > tkss_pkg::KW) ? CW : tkss_pkg::KW;

  // Configuration registers
  logic                    query_kind_q;
  logic [tkss_pkg::KW-1:0] k_q;
  tkss_pkg::score_t        radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_kind_q <= tkss_pkg::QueryTopK;
      k_q          <= tkss_pkg::KW'(10);
      radius_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tkss_pkg::CfgQueryKind: query_kind_q <= cfg_data_i[0];
        tkss_pkg::CfgK:         k_q          <= cfg_data_i[tkss_pkg::KW-1:0];
        tkss_pkg::CfgRadius:    radius_q     <= $signed(cfg_data_i[tkss_pkg::ScoreW-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Control state
  logic [CW-1:0] count_q, count_d;
  logic          drain_q, drain_d;
  logic          out_valid_q, out_valid_d;

  // Output register payload
  tkss_pkg::label_t out_label_q, out_label_d;
  tkss_pkg::score_t out_score_q, out_score_d;
  logic             out_has_q, out_has_d;
  logic             out_status_q, out_status_d;
  logic             out_end_q, out_end_d;

  tkss_pkg::cell_ctrl_t ctrl;

  // Chain wiring
  logic [K_MAX-1:0]  valid_w;
  logic [K_MAX-1:0]  gt_w;
  logic [K_MAX-1:0]  ins_w;
  tkss_pkg::score_t  score_w [K_MAX];
  tkss_pkg::label_t  label_w [K_MAX];

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    logic             prev_ins;
    tkss_pkg::score_t prev_score;
    tkss_pkg::label_t prev_label;
    tkss_pkg::score_t next_score;
    tkss_pkg::label_t next_label;

    assign valid_w[g] = count_q > CW'(g);

    if (g == 0) begin : g_head
      assign prev_ins   = 1'b0;
      assign prev_score = '0;
      assign prev_label = '0;
    end else begin : g_body
      assign prev_ins   = ins_w[g-1];
      assign prev_score = score_w[g-1];
      assign prev_label = label_w[g-1];
    end

    if (g == K_MAX - 1) begin : g_tail
      assign next_score = score_w[g];
      assign next_label = label_w[g];
    end else begin : g_mid
      assign next_score = score_w[g+1];
      assign next_label = label_w[g+1];
    end

    tkss_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid_w[g]),
      .prev_ins_i   (prev_ins),
      .prev_score_i (prev_score),
      .prev_label_i (prev_label),
      .next_score_i (next_score),
      .next_label_i (next_label),
      .gt_o         (gt_w[g]),
      .ins_o        (ins_w[g]),
      .score_o      (score_w[g]),
      .label_o      (label_w[g])
    );
  end

  // Effective k and the count after an insertion
  logic [XW-1:0] k_ext;
  logic [CW-1:0] keff;
  logic [CW-1:0] n_cap;
  logic [CW-1:0] n_inc;
  logic [CW-1:0] count_ins;
  logic          enter;
  logic          out_free;
  logic          in_acc;

  assign k_ext     = XW'(k_q);
  assign keff      = (k_ext > XW'(K_MAX)) ? CW'(K_MAX) : CW'(k_ext);
  assign n_cap     = (count_q == CW'(K_MAX)) ? CW'(K_MAX - 1) : count_q;
  assign n_inc     = n_cap + CW'(1);
  assign count_ins = (n_inc > keff) ? keff : n_inc;
  // Any valid cell worse than the new score means it beats the current worst.
  assign enter     = (count_q < keff) || (|gt_w);

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !drain_q && out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    count_d      = count_q;
    drain_d      = drain_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_label_d  = out_label_q;
    out_score_d  = out_score_q;
    out_has_d    = out_has_q;
    out_status_d = out_status_q;
    out_end_d    = out_end_q;
    ctrl.op      = tkss_pkg::CELL_HOLD;
    ctrl.score   = in_i.score;
    ctrl.label   = in_i.label;

    if (in_acc) begin
      if (in_i.abort) begin
        count_d      = '0;
        out_valid_d  = 1'b1;
        out_label_d  = '0;
        out_score_d  = '0;
        out_has_d    = 1'b0;
        out_status_d = tkss_pkg::StatusTout;
        out_end_d    = 1'b1;
      end else if (query_kind_q != tkss_pkg::QueryTopK) begin
        if (in_i.has_score && (in_i.score <= radius_q)) begin
          out_valid_d  = 1'b1;
          out_label_d  = in_i.label;
          out_score_d  = in_i.score;
          out_has_d    = 1'b1;
          out_status_d = tkss_pkg::StatusOk;
          out_end_d    = in_i.last_item;
        end else if (in_i.last_item) begin
          out_valid_d  = 1'b1;
          out_label_d  = '0;
          out_score_d  = '0;
          out_has_d    = 1'b0;
          out_status_d = tkss_pkg::StatusOk;
          out_end_d    = 1'b1;
        end
        if (in_i.last_item) begin
          count_d = '0;
        end
      end else begin
        if (in_i.has_score && enter) begin
          ctrl.op = tkss_pkg::CELL_INSERT;
          count_d = count_ins;
        end
        if (in_i.last_item) begin
          drain_d = 1'b1;
        end
      end
    end else if (drain_q && out_free) begin
      out_valid_d  = 1'b1;
      out_status_d = tkss_pkg::StatusOk;
      if (count_q == '0) begin
        // Empty list: one bare terminator
        out_label_d = '0;
        out_score_d = '0;
        out_has_d   = 1'b0;
        out_end_d   = 1'b1;
        drain_d     = 1'b0;
      end else begin
        // Pop the head and advance the chain toward it
        out_label_d = label_w[0];
        out_score_d = score_w[0];
        out_has_d   = 1'b1;
        out_end_d   = (count_q == CW'(1));
        ctrl.op     = tkss_pkg::CELL_SHIFT;
        count_d     = count_q - CW'(1);
        drain_d     = (count_q != CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_label_q  <= out_label_d;
    out_score_q  <= out_score_d;
    out_has_q    <= out_has_d;
    out_status_q <= out_status_d;
    out_end_q    <= out_end_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_label = out_label_q;
  assign out_o.result_score = out_score_q;
  assign out_o.has_entry    = out_has_q;
  assign out_o.status       = out_status_q;
  assign out_o.query_end    = out_end_q;

endmodule

### rtl/tkss_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted candidate chain: holds a score and label, inserts,
// shifts toward the worse end on insertion and toward the head on drain.
// Depends on tkss_pkg.
module tkss_cell (
  input  logic                 clk_i,
  input  tkss_pkg::cell_ctrl_t ctrl_i,
  input  logic                 valid_i,
  input  logic                 prev_ins_i,
  input  tkss_pkg::score_t     prev_score_i,
  input  tkss_pkg::label_t     prev_label_i,
  input  tkss_pkg::score_t     next_score_i,
  input  tkss_pkg::label_t     next_label_i,
  output logic                 gt_o,
  output logic                 ins_o,
  output tkss_pkg::score_t     score_o,
  output tkss_pkg::label_t     label_o
);

  tkss_pkg::score_t score_q, score_d;
  tkss_pkg::label_t label_q, label_d;

  // Strict compare keeps the earlier arrival ahead on ties.
  assign gt_o    = valid_i && (score_q > ctrl_i.score);
  assign ins_o   = !valid_i || gt_o;
  assign score_o = score_q;
  assign label_o = label_q;

  always_comb begin
    score_d = score_q;
    label_d = label_q;
    case (ctrl_i.op)
      tkss_pkg::CELL_INSERT: begin
        if (ins_o) begin
          if (prev_ins_i) begin
            score_d = prev_score_i;
            label_d = prev_label_i;
          end else begin
            score_d = ctrl_i.score;
            label_d = ctrl_i.label;
          end
        end
      end
      tkss_pkg::CELL_SHIFT: begin
        score_d = next_score_i;
        label_d = next_label_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    label_q <= label_d;
  end

endmodule
